FILE: rtl/lhp_pkg.sv
package lhp_pkg;

  // Histogram geometry
  localparam int unsigned BUCKET_COUNT = 4096;
  localparam int unsigned BKT_SHIFT    = 10;
  localparam int unsigned IDX_W        = $clog2(BUCKET_COUNT);
  localparam int unsigned COUNT_W      = 32;

  // Field widths
  localparam int unsigned LAT_W  = 64;
  localparam int unsigned SAMP_W = 32;
  localparam int unsigned TICK_W = 22;
  localparam int unsigned OUTL_W = 32;

  // Histogram total never exceeds BUCKET_COUNT * (2^COUNT_W - 1)
  localparam int unsigned TOT_W  = COUNT_W + IDX_W;
  // Ratio factors fit in 10 bits (largest is 1000)
  localparam int unsigned FAC_W  = 10;
  localparam int unsigned PROD_W = TOT_W + FAC_W;

  // Percentile selector: 50%, 99%, 99.9%, then all found
  localparam int unsigned NUM_PCT = 3;
  typedef logic [1:0] pct_t;
  localparam pct_t PCT_P50  = 2'd0;
  localparam pct_t PCT_P99  = 2'd1;
  localparam pct_t PCT_P999 = 2'd2;
  localparam pct_t PCT_DONE = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REC_WR,
    ST_SUM,
    ST_SUM_LAST,
    ST_THR,
    ST_SCAN_RD,
    ST_SCAN_ACC,
    ST_SCAN_MUL,
    ST_SCAN_CMP,
    ST_DONE
  } state_e;

  // Share numerator of each percentile
  function automatic logic [FAC_W-1:0] pct_num(pct_t k);
    logic [FAC_W-1:0] r;
    case (k)
      PCT_P50: r = FAC_W'(1);
      PCT_P99: r = FAC_W'(99);
      default: r = FAC_W'(999);
    endcase
    return r;
  endfunction

  // Share denominator of each percentile
  function automatic logic [FAC_W-1:0] pct_den(pct_t k);
    logic [FAC_W-1:0] r;
    case (k)
      PCT_P50: r = FAC_W'(2);
      PCT_P99: r = FAC_W'(100);
      default: r = FAC_W'(1000);
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/lhp_div.sv
module lhp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lhp_pkg::LAT_W-1:0]  dividend_i,
  input  logic [lhp_pkg::SAMP_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [lhp_pkg::LAT_W-1:0]  quotient_o
);

  localparam int unsigned CNT_W = $clog2(lhp_pkg::LAT_W + 1);

  logic [lhp_pkg::LAT_W-1:0]  quo_q, quo_d;
  logic [lhp_pkg::SAMP_W-1:0] rem_q, rem_d;
  logic [lhp_pkg::SAMP_W-1:0] dvs_q;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [lhp_pkg::SAMP_W:0]   rem_sh;
  logic [lhp_pkg::SAMP_W:0]   rem_sub;
  logic                       ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_q, quo_q[lhp_pkg::LAT_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = (rem_sh >= {1'b0, dvs_q});
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = done_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(lhp_pkg::LAT_W);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[lhp_pkg::SAMP_W-1:0] : rem_sh[lhp_pkg::SAMP_W-1:0];
      quo_d = {quo_q[lhp_pkg::LAT_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/latency_histogram_percentiles.sv
// Latency histogram with percentile report.
// Input channel (in_valid_i / in_stall_o) carries one item per handshake:
// action 0 records now_tick - receive_tick into a 4096-bucket histogram of
// 1024-tick buckets (last bucket collects everything beyond), action 1
// requests a report. Output channel (out_valid_o / out_stall_i) carries one
// report item: p50/p99/p99.9 bucket starts in ticks, outlier and sample
// counts, average latency and an empty flag. After a report the histogram and
// the running totals are zero. A record reads its bucket, then writes it back
// in state ST_REC_WR through the counter memory; no new item is taken until
// the write-back is done. A report makes one pass summing the buckets, three
// threshold products on the shared multiplier, then a second pass that per
// bucket reads, accumulates and clears, and multiplies, with a compare while a
// percentile is still open and a further multiply and compare per percentile
// found. The average divider runs in the background of the scan.
// After reset the counter memory is cleared at one entry per cycle, and
// in_stall_o stays high until every entry is clear. A finished report sits
// in the output register; records are taken while it waits, and a following
// report holds its result until the receiver drops out_stall_i.
module latency_histogram_percentiles (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [lhp_pkg::LAT_W-1:0]    now_tick_i,
  input  logic [lhp_pkg::LAT_W-1:0]    receive_tick_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lhp_pkg::TICK_W-1:0]   p50_ticks_o,
  output logic [lhp_pkg::TICK_W-1:0]   p99_ticks_o,
  output logic [lhp_pkg::TICK_W-1:0]   p999_ticks_o,
  output logic [lhp_pkg::OUTL_W-1:0]   outlier_count_o,
  output logic [lhp_pkg::SAMP_W-1:0]   sample_count_o,
  output logic [lhp_pkg::LAT_W-1:0]    average_ticks_o,
  output logic                         empty_res_o
);

  localparam logic [lhp_pkg::IDX_W-1:0] IDX_LAST =
    lhp_pkg::IDX_W'(lhp_pkg::BUCKET_COUNT - 1);
  localparam int unsigned HI_W = lhp_pkg::LAT_W - lhp_pkg::BKT_SHIFT - lhp_pkg::IDX_W;

  lhp_pkg::state_e state_q, state_d;

  // Counter memory
  logic [lhp_pkg::COUNT_W-1:0] mem_q [lhp_pkg::BUCKET_COUNT];
  logic [lhp_pkg::COUNT_W-1:0] rd_data_q;
  logic                        rd_en;
  logic [lhp_pkg::IDX_W-1:0]   rd_addr;
  logic                        wr_en;
  logic [lhp_pkg::IDX_W-1:0]   wr_addr;
  logic [lhp_pkg::COUNT_W-1:0] wr_data;

  // Control and datapath registers
  logic [lhp_pkg::IDX_W-1:0]   idx_q;
  lhp_pkg::pct_t               k_q;
  logic                        sum_vld_q;
  logic                        sum_last_q;
  logic                        out_vld_q;
  logic [lhp_pkg::LAT_W-1:0]   latency_total_q;
  logic [lhp_pkg::SAMP_W-1:0]  sample_total_q;
  logic [lhp_pkg::IDX_W-1:0]   addr_q;
  logic [lhp_pkg::TOT_W-1:0]   tot_q;
  logic [lhp_pkg::TOT_W-1:0]   acc_q;
  logic [lhp_pkg::PROD_W-1:0]  thr_q [lhp_pkg::NUM_PCT];
  logic [lhp_pkg::PROD_W-1:0]  prod_q;
  logic [lhp_pkg::IDX_W-1:0]   res_q [lhp_pkg::NUM_PCT];
  logic [lhp_pkg::COUNT_W-1:0] outlier_q;
  logic [lhp_pkg::SAMP_W-1:0]  samp_res_q;

  // Output registers
  logic [lhp_pkg::TICK_W-1:0]  p50_q, p99_q, p999_q;
  logic [lhp_pkg::OUTL_W-1:0]  outl_out_q;
  logic [lhp_pkg::SAMP_W-1:0]  samp_out_q;
  logic [lhp_pkg::LAT_W-1:0]   avg_out_q;
  logic                        empty_out_q;

  // Misc combinational
  logic                        in_acc;
  logic                        rec_acc;
  logic                        rep_acc;
  logic [lhp_pkg::LAT_W-1:0]   lat;
  logic [lhp_pkg::IDX_W-1:0]   rec_addr;
  logic                        idx_last;
  logic                        k_all;
  logic [lhp_pkg::PROD_W-1:0]  thr_sel;
  logic                        reached;
  logic                        advance;
  logic [lhp_pkg::TOT_W-1:0]   mul_a;
  logic [lhp_pkg::FAC_W-1:0]   mul_b;
  logic [lhp_pkg::PROD_W-1:0]  mul_p;
  logic                        div_done;
  logic [lhp_pkg::LAT_W-1:0]   div_quo;
  logic                        out_load;

  // Handshake and record bucket
  assign in_acc   = in_valid_i && !in_stall_o;
  assign rec_acc  = in_acc && !action_i;
  assign rep_acc  = in_acc && action_i;
  assign lat      = now_tick_i - receive_tick_i;
  assign rec_addr = (lat[lhp_pkg::LAT_W-1 -: HI_W] != '0) ? IDX_LAST
                  : lat[lhp_pkg::BKT_SHIFT +: lhp_pkg::IDX_W];

  // Scan conditions
  assign idx_last = (idx_q == IDX_LAST);
  assign k_all    = (k_q == lhp_pkg::PCT_DONE);
  assign thr_sel  = k_all ? '0 : thr_q[k_q];
  assign reached  = (prod_q >= thr_sel);
  assign advance  = ((state_q == lhp_pkg::ST_SCAN_MUL) && k_all)
                 || ((state_q == lhp_pkg::ST_SCAN_CMP) && !reached);
  assign out_load = (state_q == lhp_pkg::ST_DONE) && div_done
                 && (!out_vld_q || !out_stall_i);

  // Shared multiplier: thresholds tot*num, then acc*den per bucket
  always_comb begin
    if (state_q == lhp_pkg::ST_THR) begin
      mul_a = tot_q;
      mul_b = lhp_pkg::pct_num(k_q);
    end else begin
      mul_a = acc_q;
      mul_b = lhp_pkg::pct_den(k_q);
    end
  end
  assign mul_p = lhp_pkg::PROD_W'(mul_a) * lhp_pkg::PROD_W'(mul_b);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lhp_pkg::ST_CLEAR: begin
        if (idx_last) state_d = lhp_pkg::ST_IDLE;
      end
      lhp_pkg::ST_IDLE: begin
        if (rec_acc) state_d = lhp_pkg::ST_REC_WR;
        else if (rep_acc) state_d = lhp_pkg::ST_SUM;
      end
      lhp_pkg::ST_REC_WR: state_d = lhp_pkg::ST_IDLE;
      lhp_pkg::ST_SUM: begin
        if (idx_last) state_d = lhp_pkg::ST_SUM_LAST;
      end
      lhp_pkg::ST_SUM_LAST: state_d = lhp_pkg::ST_THR;
      lhp_pkg::ST_THR: begin
        if (k_q == lhp_pkg::PCT_P999) state_d = lhp_pkg::ST_SCAN_RD;
      end
      lhp_pkg::ST_SCAN_RD:  state_d = lhp_pkg::ST_SCAN_ACC;
      lhp_pkg::ST_SCAN_ACC: state_d = lhp_pkg::ST_SCAN_MUL;
      lhp_pkg::ST_SCAN_MUL: begin
        if (!k_all) state_d = lhp_pkg::ST_SCAN_CMP;
        else if (idx_last) state_d = lhp_pkg::ST_DONE;
        else state_d = lhp_pkg::ST_SCAN_RD;
      end
      lhp_pkg::ST_SCAN_CMP: begin
        if (reached) state_d = lhp_pkg::ST_SCAN_MUL;
        else if (idx_last) state_d = lhp_pkg::ST_DONE;
        else state_d = lhp_pkg::ST_SCAN_RD;
      end
      lhp_pkg::ST_DONE: begin
        if (out_load) state_d = lhp_pkg::ST_IDLE;
      end
      default: state_d = lhp_pkg::ST_IDLE;
    endcase
  end

  // State outputs: stall and memory port control
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_data    = '0;
    unique case (state_q)
      lhp_pkg::ST_CLEAR: wr_en = 1'b1;
      lhp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        rd_en      = rec_acc;
        rd_addr    = rec_addr;
      end
      lhp_pkg::ST_REC_WR: begin
        wr_en   = 1'b1;
        wr_addr = addr_q;
        wr_data = (rd_data_q == '1) ? rd_data_q
                : rd_data_q + lhp_pkg::COUNT_W'(1);
      end
      lhp_pkg::ST_SUM:      rd_en = 1'b1;
      lhp_pkg::ST_SCAN_RD:  rd_en = 1'b1;
      lhp_pkg::ST_SCAN_ACC: wr_en = 1'b1;
      lhp_pkg::ST_SUM_LAST, lhp_pkg::ST_THR, lhp_pkg::ST_SCAN_MUL,
      lhp_pkg::ST_SCAN_CMP, lhp_pkg::ST_DONE: begin
        in_stall_o = 1'b1;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // Counter memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= lhp_pkg::ST_CLEAR;
      idx_q           <= '0;
      k_q             <= lhp_pkg::PCT_P50;
      sum_vld_q       <= 1'b0;
      sum_last_q      <= 1'b0;
      out_vld_q       <= 1'b0;
      latency_total_q <= '0;
      sample_total_q  <= '0;
    end else begin
      state_q    <= state_d;
      sum_vld_q  <= (state_q == lhp_pkg::ST_SUM);
      sum_last_q <= (state_q == lhp_pkg::ST_SUM) && idx_last;

      // Bucket index walk
      if (state_q == lhp_pkg::ST_CLEAR || state_q == lhp_pkg::ST_SUM || advance) begin
        idx_q <= idx_q + lhp_pkg::IDX_W'(1);
      end else if (rep_acc || state_q == lhp_pkg::ST_SUM_LAST) begin
        idx_q <= '0;
      end

      // Percentile selector
      if (rep_acc) begin
        k_q <= lhp_pkg::PCT_P50;
      end else if (state_q == lhp_pkg::ST_THR) begin
        if (k_q == lhp_pkg::PCT_P999) begin
          k_q <= (tot_q == '0) ? lhp_pkg::PCT_DONE : lhp_pkg::PCT_P50;
        end else begin
          k_q <= k_q + 2'd1;
        end
      end else if (state_q == lhp_pkg::ST_SCAN_CMP && reached) begin
        k_q <= k_q + 2'd1;
      end

      // Running totals
      if (rec_acc) begin
        latency_total_q <= latency_total_q + lat;
        if (sample_total_q != '1) begin
          sample_total_q <= sample_total_q + lhp_pkg::SAMP_W'(1);
        end
      end else if (rep_acc) begin
        latency_total_q <= '0;
        sample_total_q  <= '0;
      end

      // Output valid
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (rec_acc) begin
      addr_q <= rec_addr;
    end
    if (rep_acc) begin
      samp_res_q <= sample_total_q;
      tot_q      <= '0;
      for (int i = 0; i < lhp_pkg::NUM_PCT; i++) begin
        res_q[i] <= '0;
      end
    end
    // First pass: histogram total and last bucket
    if (sum_vld_q) begin
      tot_q <= tot_q + lhp_pkg::TOT_W'(rd_data_q);
      if (sum_last_q) begin
        outlier_q <= rd_data_q;
      end
    end
    // Thresholds
    if (state_q == lhp_pkg::ST_THR) begin
      thr_q[k_q] <= mul_p;
    end
    if (state_q == lhp_pkg::ST_SUM_LAST) begin
      acc_q <= '0;
    end
    // Second pass
    if (state_q == lhp_pkg::ST_SCAN_ACC) begin
      acc_q <= acc_q + lhp_pkg::TOT_W'(rd_data_q);
    end
    if (state_q == lhp_pkg::ST_SCAN_MUL) begin
      prod_q <= mul_p;
    end
    if (state_q == lhp_pkg::ST_SCAN_CMP && reached && !k_all) begin
      res_q[k_q] <= idx_q;
    end
    // Result
    if (out_load) begin
      p50_q       <= lhp_pkg::TICK_W'({res_q[lhp_pkg::PCT_P50],
                                        {lhp_pkg::BKT_SHIFT{1'b0}}});
      p99_q       <= lhp_pkg::TICK_W'({res_q[lhp_pkg::PCT_P99],
                                        {lhp_pkg::BKT_SHIFT{1'b0}}});
      p999_q      <= lhp_pkg::TICK_W'({res_q[lhp_pkg::PCT_P999],
                                        {lhp_pkg::BKT_SHIFT{1'b0}}});
      outl_out_q  <= lhp_pkg::OUTL_W'(outlier_q);
      samp_out_q  <= samp_res_q;
      avg_out_q   <= (samp_res_q == '0) ? '0 : div_quo;
      empty_out_q <= (samp_res_q == '0);
    end
  end

  // Average divider, started with the report
  lhp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rep_acc),
    .dividend_i (latency_total_q),
    .divisor_i  (sample_total_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o     = out_vld_q;
  assign p50_ticks_o     = p50_q;
  assign p99_ticks_o     = p99_q;
  assign p999_ticks_o    = p999_q;
  assign outlier_count_o = outl_out_q;
  assign sample_count_o  = samp_out_q;
  assign average_ticks_o = avg_out_q;
  assign empty_res_o     = empty_out_q;

endmodule
